[hdl/rads_pkg.sv]
package rads_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = 10;
    localparam int LOG     = $clog2(ENTRIES);
    localparam int NODE_W  = LOG + 1;
    localparam int DEPTH   = 2 ** NODE_W;
    localparam int LVL_W   = $clog2(LOG + 1);
    localparam int VAL_W   = 64;
    localparam int OP_W    = 32;
    localparam int DIV_W   = OP_W - 1;
    localparam int CNT_W   = $clog2(VAL_W);

    typedef enum logic [1:0] {
        ACT_ADD,
        ACT_DIV,
        ACT_MIN,
        ACT_SUM
    } t_action;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_GOT,
        ST_PL,
        ST_PR,
        ST_EVAL,
        ST_DMIN,
        ST_DMAX,
        ST_UP,
        ST_PU1,
        ST_PU2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] min;
        logic [VAL_W-1:0] max;
        logic [VAL_W-1:0] pend;
    } t_node;

    function automatic t_node node_apply(t_node n, logic [VAL_W-1:0] x,
                                         logic [LVL_W-1:0] s);
        t_node o;
        o.pend = n.pend + x;
        o.min  = n.min + x;
        o.max  = n.max + x;
        o.sum  = n.sum + (x << s);
        return o;
    endfunction

    function automatic logic [VAL_W-1:0] smin(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

    function automatic logic [VAL_W-1:0] smax(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        return ($signed(a) < $signed(b)) ? b : a;
    endfunction

    function automatic logic is_zm(logic [VAL_W-1:0] v);
        return (v == '0) || (v == '1);
    endfunction

endpackage

[hdl/rads_mem.sv]
module rads_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [rads_pkg::NODE_W-1:0] i_waddr,
    input  rads_pkg::t_node             i_wdata,
    input  logic [rads_pkg::NODE_W-1:0] i_raddr,
    output rads_pkg::t_node             o_rdata
);
    import rads_pkg::*;

    t_node r_mem [0:DEPTH-1];
    t_node r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

[hdl/rads_div.sv]
module rads_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rads_pkg::VAL_W-1:0] i_value,
    input  logic [rads_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rads_pkg::VAL_W-1:0] o_quot
);
    import rads_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_mag;
    logic [VAL_W-1:0] r_quot;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic             r_neg;
    logic [DIV_W:0]   rem_sh;
    logic             ge;
    logic [DIV_W:0]   rem_nx;

    assign rem_sh = {r_rem, r_mag[VAL_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign rem_nx = ge ? rem_sh - {1'b0, r_div} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '1;
            r_mag  <= i_value[VAL_W-1] ? VAL_W'(0) - i_value : i_value;
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_value[VAL_W-1];
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_mag  <= {r_mag[VAL_W-2:0], 1'b0};
            r_quot <= {r_quot[VAL_W-2:0], ge};
            r_rem  <= rem_nx[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? VAL_W'(0) - (r_quot + VAL_W'(r_rem != '0)) : r_quot;

endmodule

[hdl/range_add_div_min_sum_tree.sv]
// Range add, range floor divide, range minimum and range sum over 1024 signed
// 64-bit elements held in a lazy segment tree in one node memory.
// The input channel (i_valid, o_ready) takes one word per action: i_action,
// i_range_left, i_range_right and i_operand. The output channel (o_valid,
// i_ready) returns one word for a query or for a rejected action, and nothing
// for a successful add or divide.
// One action is worked at a time; each tree node visited costs memory reads
// and writes. A divide adds two serial divisions for each fully covered node
// whose values are not all zero or minus one. A rejected action (left above
// right, or a divisor below one) goes straight to the output stage. After
// reset the block sweeps all 2048 nodes of the node memory to zero, one node a
// cycle, with o_ready low. The result sits in an output register: while
// the receiver stalls, the next action can be worked, and the block waits only
// when a second result is ready before the first was taken.
module range_add_div_min_sum_tree (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [rads_pkg::IDX_W-1:0]  i_range_left,
    input  logic [rads_pkg::IDX_W-1:0]  i_range_right,
    input  logic signed [rads_pkg::OP_W-1:0] i_operand,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [rads_pkg::VAL_W-1:0] o_result_value,
    output logic                        o_is_error
);
    import rads_pkg::*;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(ENTRIES - 1);

    t_state            r_state, n_state;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic              r_ovalid, n_ovalid;
    logic [VAL_W-1:0]  r_oval, n_oval;
    logic              r_oerr, n_oerr;
    t_action           r_act, n_act;
    logic [IDX_W-1:0]  r_l, n_l;
    logic [IDX_W-1:0]  r_r, n_r;
    logic [OP_W-1:0]   r_op, n_op;
    logic [NODE_W-1:0] r_node, n_node;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    t_node             r_nd, n_nd;
    t_node             r_cl, n_cl;
    logic [VAL_W-1:0]  r_pend, n_pend;
    logic [VAL_W-1:0]  r_nmin, n_nmin;
    logic [VAL_W-1:0]  r_acc, n_acc;
    logic              r_have, n_have;
    logic              r_err, n_err;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    t_node             mem_wdata;
    logic [NODE_W-1:0] mem_raddr;
    t_node             mem_q;

    logic              div_start;
    logic [VAL_W-1:0]  div_value;
    logic              div_done;
    logic [VAL_W-1:0]  div_quot;

    logic [IDX_W-1:0]  right_sat;
    logic              in_err;
    logic              leaf;
    logic [LVL_W-1:0]  slog;
    logic [NODE_W-1:0] node_sh;
    logic [IDX_W-1:0]  lo, hi, mid, mask;
    logic              covered;
    logic              zm;
    logic              go_left;
    logic              q_push;
    logic              div_cond;
    logic              up_right;
    logic              at_root;
    logic              is_query;
    logic              eval_finish;
    logic              eval_div;
    logic              emit_ok;

    rads_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    rads_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_value   (div_value),
        .i_divisor (r_op[DIV_W-1:0]),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign right_sat = (i_range_right > IDX_MAX) ? IDX_MAX : i_range_right;
    assign in_err = (i_range_left > right_sat)
                  || (t_action'(i_action) == ACT_DIV
                      && (i_operand == '0 || i_operand[OP_W-1]));

    assign leaf     = r_lvl == LVL_W'(LOG);
    assign slog     = LVL_W'(LOG) - r_lvl;
    assign node_sh  = r_node << slog;
    assign lo       = node_sh[IDX_W-1:0];
    assign mask     = (IDX_W'(1) << slog) - IDX_W'(1);
    assign hi       = lo | mask;
    assign mid      = lo | (mask >> 1);
    assign covered  = (r_l <= lo) && (hi <= r_r);
    assign zm       = is_zm(r_nd.min) && is_zm(r_nd.max);
    assign go_left  = r_l <= mid;
    assign q_push   = (mem_q.pend != '0) && !leaf;
    assign div_cond = (r_nd.min - r_nmin == r_nd.max - div_quot) || leaf;
    assign up_right = !r_node[0] && (r_r > hi);
    assign at_root  = r_node == NODE_W'(1);
    assign is_query = (r_act == ACT_MIN) || (r_act == ACT_SUM);
    assign emit_ok  = !r_ovalid || i_ready;

    always_comb begin
        eval_finish = 1'b0;
        eval_div    = 1'b0;
        unique case (r_act)
            ACT_ADD: eval_finish = covered;
            ACT_DIV: begin
                eval_finish = zm;
                eval_div    = !zm && covered;
            end
            ACT_MIN, ACT_SUM: eval_finish = covered;
            default: eval_finish = covered;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (&r_clr) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = in_err ? ST_EMIT : ST_RD;
                end
            end
            ST_RD:  n_state = ST_GOT;
            ST_GOT: n_state = q_push ? ST_PL : ST_EVAL;
            ST_PL:  n_state = ST_PR;
            ST_PR:  n_state = ST_EVAL;
            ST_EVAL: begin
                if (eval_finish) begin
                    n_state = ST_UP;
                end else if (eval_div) begin
                    n_state = ST_DMIN;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_DMIN: if (div_done) n_state = ST_DMAX;
            ST_DMAX: begin
                if (div_done) begin
                    n_state = div_cond ? ST_UP : ST_RD;
                end
            end
            ST_UP: begin
                if (at_root) begin
                    n_state = is_query ? ST_EMIT : ST_IDLE;
                end else if (up_right) begin
                    n_state = ST_RD;
                end else if (!is_query) begin
                    n_state = ST_PU1;
                end
            end
            ST_PU1: n_state = ST_PU2;
            ST_PU2: n_state = ST_UP;
            ST_EMIT: if (emit_ok) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr     = r_clr;
        n_ovalid  = r_ovalid && !i_ready;
        n_oval    = r_oval;
        n_oerr    = r_oerr;
        n_act     = r_act;
        n_l       = r_l;
        n_r       = r_r;
        n_op      = r_op;
        n_node    = r_node;
        n_lvl     = r_lvl;
        n_nd      = r_nd;
        n_cl      = r_cl;
        n_pend    = r_pend;
        n_nmin    = r_nmin;
        n_acc     = r_acc;
        n_have    = r_have;
        n_err     = r_err;
        o_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = r_nd;
        mem_raddr = r_node;
        div_start = 1'b0;
        div_value = r_nd.min;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + NODE_W'(1);
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_act  = t_action'(i_action);
                    n_l    = i_range_left;
                    n_r    = right_sat;
                    n_op   = i_operand;
                    n_node = NODE_W'(1);
                    n_lvl  = '0;
                    n_acc  = '0;
                    n_have = 1'b0;
                    n_err  = in_err;
                end
            end
            ST_RD: begin
                mem_raddr = r_node;
            end
            ST_GOT: begin
                n_nd      = mem_q;
                n_nd.pend = '0;
                n_pend    = mem_q.pend;
                mem_raddr = {r_node[NODE_W-2:0], 1'b0};
            end
            ST_PL: begin
                mem_we    = 1'b1;
                mem_waddr = {r_node[NODE_W-2:0], 1'b0};
                mem_wdata = node_apply(mem_q, r_pend, slog - LVL_W'(1));
                mem_raddr = {r_node[NODE_W-2:0], 1'b1};
            end
            ST_PR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_node[NODE_W-2:0], 1'b1};
                mem_wdata = node_apply(mem_q, r_pend, slog - LVL_W'(1));
            end
            ST_EVAL: begin
                mem_we = 1'b1;
                if (eval_finish) begin
                    if (r_act == ACT_ADD) begin
                        mem_wdata = node_apply(r_nd, {{(VAL_W-OP_W){r_op[OP_W-1]}}, r_op},
                                               slog);
                    end else if (r_act == ACT_SUM) begin
                        n_acc = r_acc + r_nd.sum;
                    end else if (r_act == ACT_MIN) begin
                        n_acc  = r_have ? smin(r_acc, r_nd.min) : r_nd.min;
                        n_have = 1'b1;
                    end
                end else if (eval_div) begin
                    div_start = 1'b1;
                    div_value = r_nd.min;
                end else begin
                    n_node = {r_node[NODE_W-2:0], !go_left};
                    n_lvl  = r_lvl + LVL_W'(1);
                end
            end
            ST_DMIN: begin
                if (div_done) begin
                    n_nmin    = div_quot;
                    div_start = 1'b1;
                    div_value = r_nd.max;
                end
            end
            ST_DMAX: begin
                if (div_done) begin
                    if (div_cond) begin
                        mem_we    = 1'b1;
                        mem_wdata = node_apply(r_nd, r_nmin - r_nd.min, slog);
                    end else begin
                        n_node = {r_node[NODE_W-2:0], !go_left};
                        n_lvl  = r_lvl + LVL_W'(1);
                    end
                end
            end
            ST_UP: begin
                if (!at_root) begin
                    if (up_right) begin
                        n_node = r_node + NODE_W'(1);
                    end else begin
                        n_node    = r_node >> 1;
                        n_lvl     = r_lvl - LVL_W'(1);
                        mem_raddr = {r_node[NODE_W-1:1], 1'b0};
                    end
                end
            end
            ST_PU1: begin
                n_cl      = mem_q;
                mem_raddr = {r_node[NODE_W-2:0], 1'b1};
            end
            ST_PU2: begin
                mem_we         = 1'b1;
                mem_wdata.sum  = r_cl.sum + mem_q.sum;
                mem_wdata.min  = smin(r_cl.min, mem_q.min);
                mem_wdata.max  = smax(r_cl.max, mem_q.max);
                mem_wdata.pend = '0;
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_acc;
                    n_oerr   = r_err;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oval <= n_oval;
        r_oerr <= n_oerr;
        r_act  <= n_act;
        r_l    <= n_l;
        r_r    <= n_r;
        r_op   <= n_op;
        r_node <= n_node;
        r_lvl  <= n_lvl;
        r_nd   <= n_nd;
        r_cl   <= n_cl;
        r_pend <= n_pend;
        r_nmin <= n_nmin;
        r_acc  <= n_acc;
        r_have <= n_have;
        r_err  <= n_err;
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_is_error     = r_oerr;

`ifndef SYNTHESIS
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR && r_state != ST_IDLE && r_state != ST_EMIT)
            |-> (r_lvl <= LVL_W'(LOG) && r_node != '0))
        else $error("tree walk left the node range");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_EMIT) |-> !mem_we)
        else $error("node memory written outside a walk");

    a_err_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && in_err) |=> (r_state == ST_EMIT))
        else $error("rejected word did not go to the result stage");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && eval_div) |=> (r_state == ST_DMIN && !div_done))
        else $error("divider result seen too early");
`endif

endmodule
